[rtl/gwwa_pkg.sv]
// Shared types and constants for the geometric weighted window average block.
`timescale 1ns / 1ps
`default_nettype none

package gwwa_pkg;

  // Fixed field widths
  localparam int CONF_W  = 16;  // Q4.12 confidence
  localparam int ALPHA_W = 16;  // Q0.16 alpha
  localparam int WLEN_W  = 5;   // window length register
  localparam int CLS_W   = 3;   // class index on the result channel
  localparam int IN_CLASSES = 8;  // confidence ports on the input channel
  localparam int W_W     = 17;  // Q1.16 weight
  localparam int MUL_W   = 2 * W_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [W_W-1:0] ONE_Q16 = 17'h10000;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WLEN  = 1'd1;

  // Register reset values
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd13107;
  localparam logic [WLEN_W-1:0]  WLEN_RST  = 5'd10;

  // Sequencer states
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_WRITE = 8'b0000_0010,
    S_START = 8'b0000_0100,
    S_MULC  = 8'b0000_1000,
    S_ACC   = 8'b0001_0000,
    S_WUPD  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

[rtl/gwwa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gwwa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/geometric_weighted_window_average.sv]
// Top level: per-class geometric weighted average over a window of recent frames.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted frame is stored in a circular history RAM (one 16-bit confidence per
// class per slot, 0 for absent classes), then every present class is averaged over the
// frames held, newest first, with weights 1, beta, beta^2, ... where beta = 1 - alpha
// (Q1.16, each weight truncated). Results come out in ascending class order; the last
// one of a frame carries last_of_frame. A frame is first stored class by class; then
// each present class steps through the frames held with a multiply, accumulate and
// weight-update step per frame on the single shared 17x17 multiplier and the one RAM
// read port, runs the restoring divider and waits in the output state until the output
// register is free. A frame with no class present produces no result. in_ready is
// high only between frames; a finished result may still wait in the output register
// while the next frame is taken. The history RAM needs no clearing after reset.
module geometric_weighted_window_average #(
  parameter int MAX_WINDOW  = 16,
  parameter int NUM_CLASSES = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input frame channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [gwwa_pkg::CONF_W-1:0]       in_conf_class0,
  input  wire logic [gwwa_pkg::CONF_W-1:0]       in_conf_class1,
  input  wire logic [gwwa_pkg::CONF_W-1:0]       in_conf_class2,
  input  wire logic [gwwa_pkg::CONF_W-1:0]       in_conf_class3,
  input  wire logic [gwwa_pkg::CONF_W-1:0]       in_conf_class4,
  input  wire logic [gwwa_pkg::CONF_W-1:0]       in_conf_class5,
  input  wire logic [gwwa_pkg::CONF_W-1:0]       in_conf_class6,
  input  wire logic [gwwa_pkg::CONF_W-1:0]       in_conf_class7,
  input  wire logic [gwwa_pkg::IN_CLASSES-1:0]   in_present_mask,
  // Result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [gwwa_pkg::CLS_W-1:0]        out_class_index,
  output logic      [gwwa_pkg::CONF_W-1:0]       out_smoothed_conf,
  output logic                                   out_last_of_frame,
  // Configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [gwwa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gwwa_pkg::ALPHA_W-1:0]      cfg_data
);

  localparam int CONF_W = gwwa_pkg::CONF_W;
  localparam int W_W    = gwwa_pkg::W_W;
  localparam int CLS_W  = gwwa_pkg::CLS_W;
  localparam int DEPTH  = MAX_WINDOW * NUM_CLASSES;
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int SLOT_W = MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1;
  localparam int FH_W   = $clog2(MAX_WINDOW + 1);
  localparam int FHX_W  = FH_W + 1;
  localparam int CK_W   = NUM_CLASSES > 1 ? $clog2(NUM_CLASSES) : 1;
  localparam int BOT_W  = W_W + FH_W;       // sum of weights
  localparam int TOP_W  = BOT_W + CONF_W;   // sum of confidence times weight
  localparam int MUL_W  = gwwa_pkg::MUL_W;

  gwwa_pkg::state_t state_r, state_nxt;

  logic [gwwa_pkg::ALPHA_W-1:0] alpha_r;
  logic [gwwa_pkg::WLEN_W-1:0]  wlen_r;
  logic [FH_W-1:0]              frames_held_r;
  logic [SLOT_W-1:0]            newest_slot_r;

  logic [CONF_W-1:0]      conf_r [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] pend_r;
  logic [CK_W-1:0]        wr_k_r;
  logic [CLS_W-1:0]       cls_r;
  logic [FH_W-1:0]        j_r;
  logic [SLOT_W-1:0]      rd_slot_r;
  logic [W_W-1:0]         w_r;
  logic [MUL_W-1:0]       prod_r;
  logic [TOP_W-1:0]       top_r;
  logic [BOT_W-1:0]       bot_r;
  logic [BOT_W-1:0]       rem_r;
  logic [CONF_W-1:0]      quo_r;
  logic [3:0]             div_cnt_r;
  logic                   out_valid_r;

  logic [CONF_W-1:0] in_conf_all [gwwa_pkg::IN_CLASSES];

  assign in_conf_all[0] = in_conf_class0;
  assign in_conf_all[1] = in_conf_class1;
  assign in_conf_all[2] = in_conf_class2;
  assign in_conf_all[3] = in_conf_class3;
  assign in_conf_all[4] = in_conf_class4;
  assign in_conf_all[5] = in_conf_class5;
  assign in_conf_all[6] = in_conf_class6;
  assign in_conf_all[7] = in_conf_class7;

  // Handshakes
  logic in_fire, out_fire, cfg_fire, out_load;

  assign in_ready  = (state_r == gwwa_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign in_fire   = in_valid & in_ready;
  assign out_fire  = out_valid_r & out_ready;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign out_load  = (state_r == gwwa_pkg::S_OUT) & (~out_valid_r | out_ready);

  // Effective window: zero counts as one, saturate at MAX_WINDOW
  logic [FHX_W-1:0] n_eff, fh_inc, fh_nxt;

  always_comb begin
    if (wlen_r == '0) begin
      n_eff = FHX_W'(1);
    end else if (32'(wlen_r) > MAX_WINDOW) begin
      n_eff = FHX_W'(MAX_WINDOW);
    end else begin
      n_eff = FHX_W'(wlen_r);
    end
    fh_inc = {1'b0, frames_held_r} + FHX_W'(1);
    fh_nxt = (fh_inc > n_eff) ? n_eff : fh_inc;
  end

  // Slot arithmetic around the circular buffer
  logic [SLOT_W-1:0] slot_inc, slot_dec;

  assign slot_inc = (32'(newest_slot_r) == MAX_WINDOW - 1) ? '0 : newest_slot_r + SLOT_W'(1);
  assign slot_dec = (rd_slot_r == '0) ? SLOT_W'(MAX_WINDOW - 1) : rd_slot_r - SLOT_W'(1);

  // Lowest pending class and whether it is the last of the frame
  logic [CLS_W-1:0]       low_idx;
  logic [NUM_CLASSES-1:0] cur_bit;
  logic                   is_last;

  always_comb begin
    low_idx = '0;
    cur_bit = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        low_idx = CLS_W'(i);
      end
    end
    for (int i = 0; i < NUM_CLASSES; i++) begin
      cur_bit[i] = (32'(cls_r) == i);
    end
    is_last = ((pend_r & ~cur_bit) == '0);
  end

  // History RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CONF_W-1:0] ram_wdata, ram_rdata;

  assign ram_we    = (state_r == gwwa_pkg::S_WRITE);
  assign ram_waddr = ADDR_W'(32'(newest_slot_r) * NUM_CLASSES + 32'(wr_k_r));
  assign ram_wdata = pend_r[wr_k_r] ? conf_r[wr_k_r] : '0;
  assign ram_raddr = (state_r == gwwa_pkg::S_START)
                   ? ADDR_W'(32'(newest_slot_r) * NUM_CLASSES + 32'(low_idx))
                   : ADDR_W'(32'(slot_dec) * NUM_CLASSES + 32'(cls_r));

  gwwa_ram #(
    .WIDTH (CONF_W),
    .DEPTH (DEPTH)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Shared multiplier: confidence times weight, or weight times beta
  logic [W_W-1:0]   beta, mul_a, mul_b;
  logic [MUL_W-1:0] mul_p;

  assign beta  = gwwa_pkg::ONE_Q16 - {1'b0, alpha_r};
  assign mul_a = (state_r == gwwa_pkg::S_MULC) ? {1'b0, ram_rdata} : w_r;
  assign mul_b = (state_r == gwwa_pkg::S_MULC) ? w_r : beta;
  assign mul_p = mul_a * mul_b;

  // Restoring divider step, one quotient bit per cycle
  logic [BOT_W:0]   div_trial, div_diff;
  logic             div_ge;
  logic [BOT_W-1:0] rem_step;

  assign div_trial = {rem_r, quo_r[CONF_W-1]};
  assign div_diff  = div_trial - {1'b0, bot_r};
  assign div_ge    = (div_trial >= {1'b0, bot_r});
  assign rem_step  = div_ge ? div_diff[BOT_W-1:0] : div_trial[BOT_W-1:0];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gwwa_pkg::S_IDLE:  if (in_fire) state_nxt = gwwa_pkg::S_WRITE;
      gwwa_pkg::S_WRITE: if (32'(wr_k_r) == NUM_CLASSES - 1) state_nxt = gwwa_pkg::S_START;
      gwwa_pkg::S_START: state_nxt = (pend_r == '0) ? gwwa_pkg::S_IDLE : gwwa_pkg::S_MULC;
      gwwa_pkg::S_MULC:  state_nxt = gwwa_pkg::S_ACC;
      gwwa_pkg::S_ACC:   state_nxt = gwwa_pkg::S_WUPD;
      gwwa_pkg::S_WUPD:  state_nxt = (j_r == frames_held_r) ? gwwa_pkg::S_DIV
                                                            : gwwa_pkg::S_MULC;
      gwwa_pkg::S_DIV:   if (div_cnt_r == 4'd15) state_nxt = gwwa_pkg::S_OUT;
      gwwa_pkg::S_OUT:   if (out_load) state_nxt = gwwa_pkg::S_START;
      default:           state_nxt = gwwa_pkg::S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= gwwa_pkg::S_IDLE;
      alpha_r       <= gwwa_pkg::ALPHA_RST;
      wlen_r        <= gwwa_pkg::WLEN_RST;
      frames_held_r <= '0;
      newest_slot_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        case (cfg_index)
          gwwa_pkg::REG_ALPHA: alpha_r <= cfg_data;
          gwwa_pkg::REG_WLEN:  wlen_r  <= cfg_data[gwwa_pkg::WLEN_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        frames_held_r <= fh_nxt[FH_W-1:0];
        newest_slot_r <= slot_inc;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      gwwa_pkg::S_IDLE: begin
        if (in_fire) begin
          for (int k = 0; k < NUM_CLASSES; k++) begin
            conf_r[k] <= in_conf_all[k];
          end
          pend_r <= in_present_mask[NUM_CLASSES-1:0];
          wr_k_r <= '0;
        end
      end
      gwwa_pkg::S_WRITE: begin
        wr_k_r <= wr_k_r + CK_W'(1);
      end
      gwwa_pkg::S_START: begin
        cls_r     <= low_idx;
        j_r       <= '0;
        rd_slot_r <= newest_slot_r;
        w_r       <= gwwa_pkg::ONE_Q16;
        top_r     <= '0;
        bot_r     <= '0;
      end
      gwwa_pkg::S_MULC: begin
        prod_r <= mul_p;
      end
      gwwa_pkg::S_ACC: begin
        top_r  <= top_r + TOP_W'(prod_r);
        bot_r  <= bot_r + BOT_W'(w_r);
        prod_r <= mul_p;
        j_r    <= j_r + FH_W'(1);
      end
      gwwa_pkg::S_WUPD: begin
        w_r       <= prod_r[W_W+15:16];
        rd_slot_r <= slot_dec;
        rem_r     <= top_r[TOP_W-1:CONF_W];
        quo_r     <= top_r[CONF_W-1:0];
        div_cnt_r <= '0;
      end
      gwwa_pkg::S_DIV: begin
        rem_r     <= rem_step;
        quo_r     <= {quo_r[CONF_W-2:0], div_ge};
        div_cnt_r <= div_cnt_r + 4'd1;
      end
      gwwa_pkg::S_OUT: begin
        if (out_load) begin
          out_class_index   <= cls_r;
          out_smoothed_conf <= quo_r;
          out_last_of_frame <= is_last;
          pend_r            <= pend_r & ~cur_bit;
        end
      end
      default: ;
    endcase
  end

  // Checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_accept_writes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == gwwa_pkg::S_WRITE) && (frames_held_r != '0))
    else $error("accepted frame did not start the store phase");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(frames_held_r) <= MAX_WINDOW)
    else $error("frames held exceeds the window depth");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gwwa_pkg::S_WUPD) |-> (j_r <= frames_held_r) && (j_r != '0))
    else $error("window walk ran past the frames held");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gwwa_pkg::S_DIV) |-> (rem_r < bot_r))
    else $error("divider remainder not below the divisor");

endmodule

`default_nettype wire

[sim/geometric_weighted_window_average_test.sv]
// Self-checking testbench for the geometric weighted window average block.
`timescale 1ns / 1ps

module geometric_weighted_window_average_test;

  localparam int CONF_W     = gwwa_pkg::CONF_W;
  localparam int CLS_W      = gwwa_pkg::CLS_W;
  localparam int ALPHA_W    = gwwa_pkg::ALPHA_W;
  localparam int WLEN_W     = gwwa_pkg::WLEN_W;
  localparam int IN_CLASSES = gwwa_pkg::IN_CLASSES;
  localparam int CFG_IDX_W  = gwwa_pkg::CFG_IDX_W;

  localparam int MAX_WIN      = 16;
  localparam int CLASS_CNT    = 8;
  localparam int DRAIN_CYCLES = 600;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int PLAN_ROWS    = 23;
  localparam int SEGMENTS     = 9;
  localparam int SEG_FRAMES   = 16;

  typedef struct packed {
    logic [CLASS_CNT-1:0][CONF_W-1:0] conf;
    logic [CLASS_CNT-1:0]             mask;
  } frame_t;

  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic [CONF_W-1:0] avg;
    logic              last;
  } avg_rec_t;

  // One row of the directed plan; an optional register setting goes first
  typedef struct packed {
    logic               cfg;
    logic [ALPHA_W-1:0] alpha;
    logic [WLEN_W-1:0]  wlen;
    logic [CONF_W-1:0]  even_conf;
    logic [CONF_W-1:0]  odd_conf;
    logic [7:0]         mask;
    logic               typed;
    logic [CONF_W-1:0]  typed_avg;
  } plan_row_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [CLASS_CNT-1:0][CONF_W-1:0] frame_conf = '0;
  logic [IN_CLASSES-1:0]            frame_mask = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CLS_W-1:0]  out_class_index;
  logic [CONF_W-1:0] out_smoothed_conf;
  logic              out_last_of_frame;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = gwwa_pkg::REG_ALPHA;
  logic [ALPHA_W-1:0]   cfg_data = '0;

  // Predictor state: own copy of the frame history and registers
  logic [CONF_W-1:0]  hist_mem [MAX_WIN][CLASS_CNT];
  int                 held_frames = 0;
  int                 head_slot = 0;
  logic [ALPHA_W-1:0] cur_alpha = gwwa_pkg::ALPHA_RST;
  logic [WLEN_W-1:0]  cur_wlen = gwwa_pkg::WLEN_RST;
  avg_rec_t           avg_due [$];
  avg_rec_t           due_head;

  int send_idle_pct = 10;
  int recv_idle_pct = 69;
  int fails = 0;
  int frames_sent = 0;
  int empty_frames = 0;
  int results_checked = 0;
  int cfg_writes = 0;

  geometric_weighted_window_average DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_conf_class0   (frame_conf[0]),
    .in_conf_class1   (frame_conf[1]),
    .in_conf_class2   (frame_conf[2]),
    .in_conf_class3   (frame_conf[3]),
    .in_conf_class4   (frame_conf[4]),
    .in_conf_class5   (frame_conf[5]),
    .in_conf_class6   (frame_conf[6]),
    .in_conf_class7   (frame_conf[7]),
    .in_present_mask  (frame_mask),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_class_index  (out_class_index),
    .out_smoothed_conf(out_smoothed_conf),
    .out_last_of_frame(out_last_of_frame),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run-length guard
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  function automatic plan_row_t plan_row(input logic cfg, input logic [ALPHA_W-1:0] alpha,
                                         input logic [WLEN_W-1:0] wlen,
                                         input logic [CONF_W-1:0] even_conf,
                                         input logic [CONF_W-1:0] odd_conf,
                                         input logic [7:0] mask, input logic typed,
                                         input logic [CONF_W-1:0] typed_avg);
    plan_row_t r;
    r.cfg       = cfg;
    r.alpha     = alpha;
    r.wlen      = wlen;
    r.even_conf = even_conf;
    r.odd_conf  = odd_conf;
    r.mask      = mask;
    r.typed     = typed;
    r.typed_avg = typed_avg;
    return r;
  endfunction

  // Push the frame into the history and queue one weighted average per present class
  task automatic absorb_frame(input frame_t f, input logic typed,
                              input logic [CONF_W-1:0] typed_avg);
    int         eff;
    int         slot;
    int         top_cls;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] wgt;
    logic [16:0] beta;
    avg_rec_t    r;
    eff = (cur_wlen == 0) ? 1 : ((cur_wlen > MAX_WIN) ? MAX_WIN : int'(cur_wlen));
    head_slot = (head_slot + 1) % MAX_WIN;
    for (int k = 0; k < CLASS_CNT; k++)
      hist_mem[head_slot][k] = f.mask[k] ? f.conf[k] : '0;
    held_frames = (held_frames + 1 > eff) ? eff : held_frames + 1;
    beta = gwwa_pkg::ONE_Q16 - {1'b0, cur_alpha};
    top_cls = -1;
    for (int k = 0; k < CLASS_CNT; k++)
      if (f.mask[k]) top_cls = k;
    for (int k = 0; k < CLASS_CNT; k++) begin
      if (f.mask[k]) begin
        num = '0;
        den = '0;
        wgt = 64'(gwwa_pkg::ONE_Q16);
        // newest frame first, weight shrinks by beta each step back
        for (int j = 0; j < held_frames; j++) begin
          slot = (head_slot + MAX_WIN - j) % MAX_WIN;
          num  = num + 64'(hist_mem[slot][k]) * wgt;
          den  = den + wgt;
          wgt  = (wgt * 64'(beta)) >> 16;
        end
        r.cls  = CLS_W'(k);
        r.avg  = typed ? typed_avg : CONF_W'(num / den);
        r.last = (k == top_cls);
        avg_due.push_back(r);
      end
    end
    frames_sent++;
    if (f.mask == '0) empty_frames++;
  endtask

  // Present one frame, with a random gap first, and wait for its transaction
  task automatic send_frame(input frame_t f, input logic typed,
                            input logic [CONF_W-1:0] typed_avg);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    frame_conf <= f.conf;
    frame_mask <= f.mask;
    do @(posedge clk); while (!in_ready);
    absorb_frame(f, typed, typed_avg);
  endtask

  // Let every pending average come out, then give an empty frame time to finish
  task automatic settle_block();
    in_valid <= 1'b0;
    while (avg_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write alpha, then window length; junk in the unused data bits of the latter
  task automatic program_regs(input logic [ALPHA_W-1:0] alpha, input logic [WLEN_W-1:0] wlen);
    logic [ALPHA_W-WLEN_W-1:0] pad;
    pad = ($urandom_range(1) == 0) ? '0 : (ALPHA_W-WLEN_W)'($urandom);
    cfg_valid <= 1'b1;
    cfg_index <= gwwa_pkg::REG_ALPHA;
    cfg_data  <= alpha;
    do @(posedge clk); while (!cfg_ready);
    cur_alpha = alpha;
    cfg_index <= gwwa_pkg::REG_WLEN;
    cfg_data  <= {pad, wlen};
    do @(posedge clk); while (!cfg_ready);
    cur_wlen = wlen;
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // Result side: random back-pressure and in-order field checks
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (avg_due.size() == 0) begin
        fails++;
        $error("unexpected result transaction: class %0d conf %h", out_class_index,
               out_smoothed_conf);
      end else begin
        due_head = avg_due.pop_front();
        results_checked++;
        if (out_class_index !== due_head.cls) begin
          fails++;
          $error("class_index: expected %0d, got %0d", due_head.cls, out_class_index);
        end
        if (out_smoothed_conf !== due_head.avg) begin
          fails++;
          $error("smoothed_conf: expected %h, got %h", due_head.avg, out_smoothed_conf);
        end
        if (out_last_of_frame !== due_head.last) begin
          fails++;
          $error("last_of_frame: expected %b, got %b", due_head.last, out_last_of_frame);
        end
      end
    end
  end

  initial begin
    plan_row_t          plan [PLAN_ROWS];
    frame_t             f;
    logic [ALPHA_W-1:0] alpha_pick;
    logic [WLEN_W-1:0]  wlen_pick;
    int                 mode;

    for (int s = 0; s < MAX_WIN; s++)
      for (int k = 0; k < CLASS_CNT; k++) hist_mem[s][k] = '0;

    // Directed plan, reset registers unless a row sets new ones
    // history is all zero right after reset, so a zero frame averages to zero
    plan[0]  = plan_row(1'b0, '0, '0, 16'h0000, 16'h0000, 8'hFF, 1'b1, 16'h0000);
    plan[1]  = plan_row(1'b0, '0, '0, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, '0);
    // empty mask: frame stored as zeros, nothing comes out
    plan[2]  = plan_row(1'b0, '0, '0, 16'hFFFF, 16'hFFFF, 8'h00, 1'b0, '0);
    plan[3]  = plan_row(1'b0, '0, '0, 16'hAAAA, 16'h5555, 8'h55, 1'b0, '0);
    plan[4]  = plan_row(1'b0, '0, '0, 16'hAAAA, 16'h5555, 8'hAA, 1'b0, '0);
    plan[5]  = plan_row(1'b0, '0, '0, 16'h0000, 16'hC001, 8'h80, 1'b0, '0);
    plan[6]  = plan_row(1'b0, '0, '0, 16'h1234, 16'h0000, 8'h01, 1'b0, '0);
    plan[7]  = plan_row(1'b0, '0, '0, 16'h8001, 16'h7FFE, 8'hFF, 1'b0, '0);
    // alpha zero gives a plain mean; window above the maximum saturates
    plan[8]  = plan_row(1'b1, 16'd0, 5'd31, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, '0);
    plan[9]  = plan_row(1'b0, '0, '0, 16'h0000, 16'h0000, 8'hFF, 1'b0, '0);
    plan[10] = plan_row(1'b0, '0, '0, 16'h4000, 16'h2000, 8'hF0, 1'b0, '0);
    // largest alpha: weights collapse after the newest frame
    plan[11] = plan_row(1'b1, 16'hFFFF, 5'd16, 16'hFFFF, 16'h0001, 8'hFF, 1'b0, '0);
    plan[12] = plan_row(1'b0, '0, '0, 16'h0000, 16'hFFFF, 8'h0F, 1'b0, '0);
    // window zero acts as one and cuts the held history: output equals input
    plan[13] = plan_row(1'b1, 16'hFFFF, 5'd0, 16'h7FFF, 16'h7FFF, 8'hFF, 1'b1, 16'h7FFF);
    plan[14] = plan_row(1'b0, '0, '0, 16'hFFFF, 16'hFFFF, 8'hC3, 1'b1, 16'hFFFF);
    plan[15] = plan_row(1'b0, '0, '0, 16'h0001, 16'h0001, 8'h3C, 1'b1, 16'h0001);
    plan[16] = plan_row(1'b1, 16'd1, 5'd17, 16'h0000, 16'hFFFF, 8'hFF, 1'b0, '0);
    plan[17] = plan_row(1'b0, '0, '0, 16'hFFFF, 16'h0000, 8'hFF, 1'b0, '0);
    plan[18] = plan_row(1'b1, 16'h8000, 5'd2, 16'h1000, 16'h1000, 8'hFF, 1'b0, '0);
    plan[19] = plan_row(1'b0, '0, '0, 16'h3000, 16'h3000, 8'hFF, 1'b0, '0);
    plan[20] = plan_row(1'b0, '0, '0, 16'h5000, 16'h5000, 8'hFF, 1'b0, '0);
    plan[21] = plan_row(1'b1, gwwa_pkg::ALPHA_RST, gwwa_pkg::WLEN_RST, 16'h0000, 16'h0000,
                        8'h00, 1'b0, '0);
    plan[22] = plan_row(1'b0, '0, '0, 16'h0F0F, 16'hF0F0, 8'hFF, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].cfg) begin
        settle_block();
        program_regs(plan[i].alpha, plan[i].wlen);
      end
      for (int k = 0; k < CLASS_CNT; k++)
        f.conf[k] = k[0] ? plan[i].odd_conf : plan[i].even_conf;
      f.mask = plan[i].mask;
      send_frame(f, plan[i].typed, plan[i].typed_avg);
    end

    // Random segments, each under a fresh register setting
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      send_idle_pct = (seg < 3) ? 10 : ((seg < 6) ? 69 : 0);
      recv_idle_pct = (seg < 3) ? 69 : ((seg < 6) ? 10 : 0);
      mode = $urandom_range(5);
      alpha_pick = (mode == 0) ? 16'd0 :
                   (mode == 1) ? 16'hFFFF :
                   (mode == 2) ? 16'($urandom_range(1, 255)) : 16'($urandom);
      wlen_pick = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                           : 5'($urandom_range(1, 16));
      settle_block();
      program_regs(alpha_pick, wlen_pick);
      for (int n = 0; n < SEG_FRAMES; n++) begin
        mode = $urandom_range(19);
        if (mode == 0)      f.mask = 8'h00;
        else if (mode < 4)  f.mask = 8'hFF;
        else if (mode < 6)  f.mask = 8'(1 << $urandom_range(7));
        else                f.mask = 8'($urandom);
        for (int k = 0; k < CLASS_CNT; k++) begin
          mode = $urandom_range(9);
          f.conf[k] = (mode == 0) ? 16'hFFFF : (mode == 1) ? 16'h0000 : 16'($urandom);
        end
        send_frame(f, 1'b0, '0);
      end
    end

    settle_block();
    $display("Checked %0d class averages from %0d frames (%0d with no class present)",
             results_checked, frames_sent, empty_frames);
    $display("under %0d register settings and three back-pressure profiles", cfg_writes);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
